// ===== hdl/rfd_pkg.sv =====
// Shared types, codes and CRC helpers for the referee frame deframer.
// No dependencies; used by referee_frame_deframer_core.
package rfd_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_SEQ    = 3'd3,
        PH_HCRC   = 3'd4,
        PH_BODY   = 3'd5
    } t_phase;

    // Per-item event code
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_OK       = 3'd1,
        EV_HCRC_ERR = 3'd2,
        EV_LEN_ERR  = 3'd3,
        EV_CRC_ERR  = 3'd4
    } t_event;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_BYTE   = 2'd0;
    localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd1;

    // Register reset values
    localparam logic [7:0] START_BYTE_RST   = 8'hA5;
    localparam logic [8:0] LENGTH_LIMIT_RST = 9'd504;

    // Frame layout: header (5) + command id (2) + trailing CRC16 (2)
    localparam logic [16:0] FRAME_OVERHEAD = 17'd9;
    localparam logic [9:0]  POS_SEQ        = 10'd3;
    localparam logic [9:0]  POS_CMD_LO     = 10'd5;
    localparam logic [9:0]  POS_CMD_HI     = 10'd6;

    // CRC constants (reflected forms, no final xor)
    localparam logic [7:0]  CRC8_INIT  = 8'hFF;
    localparam logic [7:0]  CRC8_POLY  = 8'h8C;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'h8408;

    // One byte through the reflected CRC8
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // One byte through the reflected CRC16
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/rfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/referee_frame_deframer_core.sv =====
// Referee frame deframer: one item per cycle, back to back, in either direction, while the output is not stalled.
// A result is formed in the accept cycle (parser update and store access), then
// passes the store read register and stage 1, then the output register. The
// store has one write port and one read port.
// Reset (i_rst_n low, synchronous): parser back to hunting, counters and flags
// cleared, registers to defaults; the frame store is not cleared.
module referee_frame_deframer_core
    import rfd_pkg::*;
#(
    parameter int FRAME_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    input  logic [8:0]  i_read_index,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [15:0] o_command_id,
    output logic [8:0]  o_payload_length,
    output logic [7:0]  o_sequence_res,
    output logic [31:0] o_frame_total,
    output logic        o_data_valid,
    output logic [7:0]  o_read_data
);

    localparam int AW = $clog2(FRAME_BYTES);

    // configuration registers
    logic [7:0] r_start_byte;
    logic [8:0] r_length_limit;

    // parser state
    t_phase      r_phase, n_phase;
    logic [9:0]  r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_crc8, n_crc8;
    logic [15:0] r_crc16, n_crc16;
    logic [7:0]  r_seq_cap, n_seq_cap;
    logic [15:0] r_cmd_cap, n_cmd_cap;

    // last good frame
    logic [31:0] r_good, n_good;
    logic        r_valid_flag, n_valid_flag;
    logic [15:0] r_last_cmd, n_last_cmd;
    logic [8:0]  r_last_len, n_last_len;
    logic [7:0]  r_last_seq, n_last_seq;

    // stage 1: result waiting on the store read
    logic        r_s1_valid;
    t_event      r_s1_event;
    logic        r_s1_kind;
    logic        r_s1_rd_ok;
    logic [15:0] r_s1_cmd;
    logic [8:0]  r_s1_len;
    logic [7:0]  r_s1_seq;
    logic [31:0] r_s1_total;
    logic        r_s1_dvalid;

    // output register
    logic        r_o_valid;
    t_event      r_o_event;
    logic        r_o_kind;
    logic [15:0] r_o_cmd;
    logic [8:0]  r_o_len;
    logic [7:0]  r_o_seq;
    logic [31:0] r_o_total;
    logic        r_o_dvalid;
    logic [7:0]  r_o_rdata;

    logic          out_free;
    logic          s1_move;
    logic          in_acc;
    logic          rx_acc;
    t_event        ev;
    logic          st_we;
    logic [9:0]    st_wpos;
    logic          rd_ok;
    logic [9:0]    pos_inc;
    logic [15:0]   crc16_upd;
    logic [7:0]    ram_q;

    // handshake and pipeline advance
    assign out_free   = !r_o_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign rx_acc     = in_acc && !i_kind;
    assign rd_ok      = i_kind && (32'(i_read_index) < 32'(FRAME_BYTES));
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte   <= START_BYTE_RST;
            r_length_limit <= LENGTH_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_BYTE:   r_start_byte   <= i_cfg_data[7:0];
                CFG_LENGTH_LIMIT: r_length_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parser next state
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_len        = r_len;
        n_crc8       = r_crc8;
        n_crc16      = r_crc16;
        n_seq_cap    = r_seq_cap;
        n_cmd_cap    = r_cmd_cap;
        n_good       = r_good;
        n_valid_flag = r_valid_flag;
        n_last_cmd   = r_last_cmd;
        n_last_len   = r_last_len;
        n_last_seq   = r_last_seq;
        ev           = EV_NONE;
        st_we        = 1'b0;
        st_wpos      = r_pos;
        pos_inc      = r_pos + 10'd1;
        crc16_upd    = crc16_next(r_crc16, i_rx_byte);

        if (rx_acc) begin
            if (r_phase != PH_HUNT) begin
                // store, fold into CRC16, advance
                st_we   = 32'(r_pos) < 32'(FRAME_BYTES);
                n_crc16 = crc16_upd;
                n_pos   = pos_inc;
            end
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_start_byte) begin
                        st_we   = 1'b1;
                        st_wpos = '0;
                        n_crc8  = crc8_next(CRC8_INIT, i_rx_byte);
                        n_crc16 = crc16_next(CRC16_INIT, i_rx_byte);
                        n_pos   = 10'd1;
                        n_phase = PH_LEN_LO;
                    end else begin
                        n_pos = '0;
                        n_len = '0;
                    end
                end
                PH_LEN_LO: begin
                    n_len   = {8'h00, i_rx_byte};
                    n_crc8  = crc8_next(r_crc8, i_rx_byte);
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len  = {i_rx_byte, r_len[7:0]};
                    n_crc8 = crc8_next(r_crc8, i_rx_byte);
                    if (n_len < {7'd0, r_length_limit}) begin
                        n_phase = PH_SEQ;
                    end else begin
                        ev      = EV_LEN_ERR;
                        n_phase = PH_HUNT;
                        n_pos   = '0;
                    end
                end
                PH_SEQ: begin
                    n_crc8    = crc8_next(r_crc8, i_rx_byte);
                    n_seq_cap = i_rx_byte;
                    n_phase   = PH_HCRC;
                end
                PH_HCRC: begin
                    if (r_crc8 == i_rx_byte) begin
                        n_phase = PH_BODY;
                    end else begin
                        ev      = EV_HCRC_ERR;
                        n_phase = PH_HUNT;
                        n_pos   = '0;
                    end
                end
                PH_BODY: begin
                    // command id bytes sit right after the header
                    if (r_pos == POS_CMD_LO) begin
                        n_cmd_cap[7:0] = i_rx_byte;
                    end
                    if (r_pos == POS_CMD_HI) begin
                        n_cmd_cap[15:8] = i_rx_byte;
                    end
                    if ({7'd0, pos_inc} >= ({1'b0, r_len} + FRAME_OVERHEAD)) begin
                        if (crc16_upd == 16'd0) begin
                            ev           = EV_OK;
                            n_last_cmd   = r_cmd_cap;
                            n_last_len   = r_len[8:0];
                            n_last_seq   = r_seq_cap;
                            n_good       = r_good + 32'd1;
                            n_valid_flag = 1'b1;
                        end else begin
                            ev = EV_CRC_ERR;
                        end
                        n_phase = PH_HUNT;
                        n_pos   = '0;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_pos   = '0;
                end
            endcase
        end
    end

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_pos        <= '0;
            r_len        <= '0;
            r_crc8       <= CRC8_INIT;
            r_crc16      <= CRC16_INIT;
            r_good       <= '0;
            r_valid_flag <= 1'b0;
            r_last_cmd   <= '0;
            r_last_len   <= '0;
            r_last_seq   <= '0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_crc8       <= n_crc8;
            r_crc16      <= n_crc16;
            r_good       <= n_good;
            r_valid_flag <= n_valid_flag;
            r_last_cmd   <= n_last_cmd;
            r_last_len   <= n_last_len;
            r_last_seq   <= n_last_seq;
        end
    end

    // frame byte captures, overwritten each frame
    always_ff @(posedge i_clk) begin
        r_seq_cap <= n_seq_cap;
        r_cmd_cap <= n_cmd_cap;
    end

    // frame store
    rfd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (AW'(st_wpos)),
        .i_wdata (i_rx_byte),
        .i_re    (in_acc && rd_ok),
        .i_raddr (AW'(i_read_index)),
        .o_rdata (ram_q)
    );

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload: state after the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_event  <= ev;
            r_s1_kind   <= i_kind;
            r_s1_rd_ok  <= rd_ok;
            r_s1_cmd    <= n_last_cmd;
            r_s1_len    <= n_last_len;
            r_s1_seq    <= n_last_seq;
            r_s1_total  <= n_good;
            r_s1_dvalid <= n_valid_flag;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    // output register payload, store read data joins here
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_event  <= r_s1_event;
            r_o_kind   <= r_s1_kind;
            r_o_cmd    <= r_s1_cmd;
            r_o_len    <= r_s1_len;
            r_o_seq    <= r_s1_seq;
            r_o_total  <= r_s1_total;
            r_o_dvalid <= r_s1_dvalid;
            r_o_rdata  <= r_s1_rd_ok ? ram_q : 8'h00;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_event_res      = r_o_event;
    assign o_command_id     = r_o_cmd;
    assign o_payload_length = r_o_len;
    assign o_sequence_res   = r_o_seq;
    assign o_frame_total    = r_o_total;
    assign o_data_valid     = r_o_dvalid;
    assign o_read_data      = r_o_rdata;

    // checks
    a_good_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_acc && ev == EV_OK) |=> (r_good == $past(r_good) + 32'd1))
        else $error("good frame count did not advance");

    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_valid_flag))
        else $error("data valid flag cleared without reset");

    a_body_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_pos >= POS_CMD_LO && r_pos < 10'd520))
        else $error("body position out of frame range");

    a_read_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind) |-> (r_o_event == EV_NONE))
        else $error("read item reported a parser event");

endmodule
